// File: design/face_depth_order_engine_assert.svh
// Assertion macros shared by the checkers of the face depth ordering block.
// Depends on nothing; every macro takes its own clock and active-low reset.
`ifndef FACE_DEPTH_ORDER_ENGINE_ASSERT_SVH
`define FACE_DEPTH_ORDER_ENGINE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define FDO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fdo check failed");

// The consequent must hold in the same cycle as the antecedent.
`define FDO_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fdo check failed");

`endif

// File: design/fdo_pkg.sv
// Shared types and constants of the face depth ordering block.
// Used by the cell, the chain, the top level and the checker; no dependencies.
package fdo_pkg;

  localparam int MAX_FACES_DEF = 64;
  localparam int DEPTH_W       = 32;
  localparam int BLEND_W       = 3;
  localparam int FACE_IDX_W    = 6;

  // Shape codes.
  localparam logic [1:0] SHAPE_TRI  = 2'd0;
  localparam logic [1:0] SHAPE_QUAD = 2'd1;

  // Opaque blend code.
  localparam logic [BLEND_W-1:0] BLEND_OPAQUE = 3'd0;

  // One face request on the input channel.
  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic [1:0]                shape_code;
    logic                      textured;
    logic [BLEND_W-1:0]        texture_blend;
    logic                      transparent;
    logic                      texture_ok;
    logic                      last;
  } fdo_in_t;

  // One result request on the output channel.
  typedef struct packed {
    logic [FACE_IDX_W-1:0] face_index;
    logic [BLEND_W-1:0]    draw_blend;
    logic                  is_quad;
    logic                  frame_ok;
    logic                  last_result;
  } fdo_out_t;

  // Attributes a cell keeps for a stored face.
  typedef struct packed {
    logic               is_quad;
    logic               textured;
    logic [BLEND_W-1:0] texture_blend;
    logic               transparent;
  } fdo_attr_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } fdo_cell_ctrl_t;

endpackage

// File: design/fdo_cell.sv
// One cell of the sorting chain: holds a single face and its arrival index.
// Depends on fdo_pkg for the attribute and command types.
module fdo_cell #(
  parameter int IDX_W = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fdo_pkg::fdo_cell_ctrl_t          ctrl_i,
  input  logic signed [fdo_pkg::DEPTH_W-1:0] new_depth_i,
  input  fdo_pkg::fdo_attr_t               new_attr_i,
  input  logic [IDX_W-1:0]                 new_idx_i,
  input  logic                             prev_valid_i,
  input  logic signed [fdo_pkg::DEPTH_W-1:0] prev_depth_i,
  input  fdo_pkg::fdo_attr_t               prev_attr_i,
  input  logic [IDX_W-1:0]                 prev_idx_i,
  input  logic                             prev_cond_i,
  input  logic                             next_valid_i,
  input  logic signed [fdo_pkg::DEPTH_W-1:0] next_depth_i,
  input  fdo_pkg::fdo_attr_t               next_attr_i,
  input  logic [IDX_W-1:0]                 next_idx_i,
  output logic                             valid_o,
  output logic signed [fdo_pkg::DEPTH_W-1:0] depth_o,
  output fdo_pkg::fdo_attr_t               attr_o,
  output logic [IDX_W-1:0]                 idx_o,
  output logic                             cond_o
);

  logic                             valid_q, valid_d;
  logic signed [fdo_pkg::DEPTH_W-1:0] depth_q, depth_d;
  fdo_pkg::fdo_attr_t               attr_q, attr_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;

  // The new face arrives after every stored one, so it goes ahead on equal depth.
  assign cond_o = !valid_q || (new_depth_i >= depth_q);

  // Clear, keep, shift down from the previous cell, take the new face, or shift up.
  always_comb begin
    valid_d = valid_q;
    depth_d = depth_q;
    attr_d  = attr_q;
    idx_d   = idx_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert) begin
      if (prev_cond_i) begin
        valid_d = prev_valid_i;
        depth_d = prev_depth_i;
        attr_d  = prev_attr_i;
        idx_d   = prev_idx_i;
      end else if (cond_o) begin
        valid_d = 1'b1;
        depth_d = new_depth_i;
        attr_d  = new_attr_i;
        idx_d   = new_idx_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      depth_d = next_depth_i;
      attr_d  = next_attr_i;
      idx_d   = next_idx_i;
    end
  end

  // Occupancy is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Face payload needs no reset.
  always_ff @(posedge clk_i) begin
    depth_q <= depth_d;
    attr_q  <= attr_d;
    idx_q   <= idx_d;
  end

  assign valid_o = valid_q;
  assign depth_o = depth_q;
  assign attr_o  = attr_q;
  assign idx_o   = idx_q;

endmodule

// File: design/fdo_chain.sv
// Row of sorting cells kept in draw order, first-drawn face in cell zero.
// Depends on fdo_pkg and fdo_cell.
module fdo_chain #(
  parameter int MAX_FACES = fdo_pkg::MAX_FACES_DEF,
  parameter int IDX_W     = $clog2(MAX_FACES)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fdo_pkg::fdo_cell_ctrl_t          ctrl_i,
  input  logic signed [fdo_pkg::DEPTH_W-1:0] new_depth_i,
  input  fdo_pkg::fdo_attr_t               new_attr_i,
  input  logic [IDX_W-1:0]                 new_idx_i,
  output logic                             head_valid_o,
  output fdo_pkg::fdo_attr_t               head_attr_o,
  output logic [IDX_W-1:0]                 head_idx_o
);

  logic                             valid [MAX_FACES];
  logic signed [fdo_pkg::DEPTH_W-1:0] depth [MAX_FACES];
  fdo_pkg::fdo_attr_t               attr  [MAX_FACES];
  logic [IDX_W-1:0]                 idx   [MAX_FACES];
  logic                             cond  [MAX_FACES];

  for (genvar k = 0; k < MAX_FACES; k++) begin : g_cell
    logic                             pv, pc, nv;
    logic signed [fdo_pkg::DEPTH_W-1:0] pd, nd;
    fdo_pkg::fdo_attr_t               pa, na;
    logic [IDX_W-1:0]                 pi, ni;

    // The head cell has no earlier neighbour.
    if (k == 0) begin : g_first
      assign pv = 1'b0;
      assign pc = 1'b0;
      assign pd = '0;
      assign pa = '0;
      assign pi = '0;
    end else begin : g_prev
      assign pv = valid[k-1];
      assign pc = cond[k-1];
      assign pd = depth[k-1];
      assign pa = attr[k-1];
      assign pi = idx[k-1];
    end

    // The tail cell empties when the chain shifts towards the head.
    if (k == MAX_FACES - 1) begin : g_last
      assign nv = 1'b0;
      assign nd = '0;
      assign na = '0;
      assign ni = '0;
    end else begin : g_next
      assign nv = valid[k+1];
      assign nd = depth[k+1];
      assign na = attr[k+1];
      assign ni = idx[k+1];
    end

    fdo_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .new_depth_i  (new_depth_i),
      .new_attr_i   (new_attr_i),
      .new_idx_i    (new_idx_i),
      .prev_valid_i (pv),
      .prev_depth_i (pd),
      .prev_attr_i  (pa),
      .prev_idx_i   (pi),
      .prev_cond_i  (pc),
      .next_valid_i (nv),
      .next_depth_i (nd),
      .next_attr_i  (na),
      .next_idx_i   (ni),
      .valid_o      (valid[k]),
      .depth_o      (depth[k]),
      .attr_o       (attr[k]),
      .idx_o        (idx[k]),
      .cond_o       (cond[k])
    );
  end

  assign head_valid_o = valid[0];
  assign head_attr_o  = attr[0];
  assign head_idx_o   = idx[0];

endmodule

// File: design/face_depth_order_engine.sv
// Face depth ordering block: sorts a frame of faces far first and resolves blending.
// Depends on fdo_pkg and fdo_chain.
//
// Input channel (in_valid_i, in_stall_o, in_data_i): one face per request,
// one request per cycle while a frame is being collected. Each face is
// placed straight into its sorted position in a chain of MAX_FACES cells.
// After the request marked last, the input stalls until the frame's final
// result has been loaded into the output register.
// Output channel (out_valid_o, out_stall_i, out_data_o): results come in
// draw order, one per cycle while the output is not stalled, from a single
// output register; the first is loaded from the chain once the sequencer
// has entered its emit state. Without stalls the next frame's first face
// is taken at the edge where the previous frame's last result leaves. A bad frame
// (invalid shape, unresolved texture, or more than MAX_FACES faces) gives
// one failure result, loaded into the output register from the fail state.
// A stall on the output holds the register and freezes the chain shift.
// Configuration (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the start
// blend register and is always ready. Reset empties the chain, clears the
// start blend and leaves the block collecting a new frame.
module face_depth_order_engine #(
  parameter int MAX_FACES = fdo_pkg::MAX_FACES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fdo_pkg::fdo_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fdo_pkg::fdo_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fdo_pkg::BLEND_W-1:0]  cfg_data_i
);

  localparam int IDX_W    = $clog2(MAX_FACES);
  localparam int CNT_W    = $clog2(MAX_FACES + 1);
  localparam int FaceIdxW = fdo_pkg::FACE_IDX_W;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_EMIT,
    ST_FAIL
  } state_e;

  state_e                        state_q;
  logic [CNT_W-1:0]              count_q;
  logic                          ovf_q;
  logic                          bad_q;
  logic [fdo_pkg::BLEND_W-1:0]   init_blend_q;
  logic [fdo_pkg::BLEND_W-1:0]   run_blend_q;
  logic                          out_valid_q;
  logic                          out_valid_d;
  fdo_pkg::fdo_out_t             out_q;
  fdo_pkg::fdo_out_t             out_d;

  logic                          in_acc;
  logic                          full;
  logic                          face_bad;
  logic                          frame_bad;
  logic                          slot_free;
  logic [fdo_pkg::BLEND_W-1:0]   blend_next;
  fdo_pkg::fdo_cell_ctrl_t       ctrl;
  fdo_pkg::fdo_attr_t            new_attr;
  logic                          head_valid;
  fdo_pkg::fdo_attr_t            head_attr;
  logic [IDX_W-1:0]              head_idx;

  // Handshakes.
  assign in_stall_o  = (state_q != ST_COLLECT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Face checks at insertion time.
  assign full      = (count_q == CNT_W'(MAX_FACES));
  assign face_bad  = (in_data_i.shape_code != fdo_pkg::SHAPE_TRI &&
                      in_data_i.shape_code != fdo_pkg::SHAPE_QUAD) ||
                     !in_data_i.texture_ok;
  assign frame_bad = ovf_q || bad_q || full || face_bad;

  assign new_attr.is_quad       = (in_data_i.shape_code == fdo_pkg::SHAPE_QUAD);
  assign new_attr.textured      = in_data_i.textured;
  assign new_attr.texture_blend = in_data_i.texture_blend;
  assign new_attr.transparent   = in_data_i.transparent;

  // Chain commands.
  assign ctrl.insert = in_acc && !full;
  assign ctrl.pop    = (state_q == ST_EMIT) && slot_free && head_valid;
  assign ctrl.clear  = (state_q == ST_FAIL) && slot_free;

  // Blend mode carried forward by the face at the head of the chain.
  assign blend_next = head_attr.textured ? head_attr.texture_blend : run_blend_q;

  // Next contents of the output register: a popped face or the failure result.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (ctrl.pop) begin
      out_valid_d       = 1'b1;
      out_d.face_index  = FaceIdxW'(head_idx);
      out_d.draw_blend  = head_attr.transparent ? blend_next : fdo_pkg::BLEND_OPAQUE;
      out_d.is_quad     = head_attr.is_quad;
      out_d.frame_ok    = 1'b1;
      out_d.last_result = (count_q == CNT_W'(1));
    end else if (ctrl.clear) begin
      out_valid_d       = 1'b1;
      out_d             = '0;
      out_d.last_result = 1'b1;
    end
  end

  fdo_chain #(
    .MAX_FACES(MAX_FACES),
    .IDX_W    (IDX_W)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .new_depth_i  (in_data_i.depth),
    .new_attr_i   (new_attr),
    .new_idx_i    (count_q[IDX_W-1:0]),
    .head_valid_o (head_valid),
    .head_attr_o  (head_attr),
    .head_idx_o   (head_idx)
  );

  // Sequencer, frame bookkeeping and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_COLLECT;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      bad_q        <= 1'b0;
      init_blend_q <= fdo_pkg::BLEND_OPAQUE;
      run_blend_q  <= fdo_pkg::BLEND_OPAQUE;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        init_blend_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      case (state_q)
        ST_COLLECT: begin
          if (in_acc) begin
            if (!full) begin
              count_q <= count_q + CNT_W'(1);
            end
            if (in_data_i.last) begin
              ovf_q       <= 1'b0;
              bad_q       <= 1'b0;
              run_blend_q <= init_blend_q;
              state_q     <= frame_bad ? ST_FAIL : ST_EMIT;
            end else begin
              ovf_q <= ovf_q || full;
              bad_q <= bad_q || (face_bad && !full);
            end
          end
        end
        ST_EMIT: begin
          if (ctrl.pop) begin
            run_blend_q <= blend_next;
            count_q     <= count_q - CNT_W'(1);
            if (count_q == CNT_W'(1)) begin
              state_q <= ST_COLLECT;
            end
          end
        end
        ST_FAIL: begin
          if (slot_free) begin
            count_q <= '0;
            state_q <= ST_COLLECT;
          end
        end
        default: begin
          state_q <= ST_COLLECT;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/fdo_checker.sv
// Port-level checks of the face depth ordering block, bound to its top level.
// Depends on fdo_pkg and the assertion macros in face_depth_order_engine_assert.svh.
`include "face_depth_order_engine_assert.svh"

module fdo_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input fdo_pkg::fdo_in_t            in_data_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input fdo_pkg::fdo_out_t           out_data_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [fdo_pkg::BLEND_W-1:0] cfg_data_i
);

  logic in_acc;
  logic cfg_seen;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_seen = cfg_valid_i && (cfg_data_i == cfg_data_i);

  // A stalled result request holds.
  `FDO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // The failure result closes the frame and carries zero fields.
  `FDO_ASSERT_SAME(a_fail_shape, clk_i, rst_ni, out_valid_o && !out_data_o.frame_ok, out_data_o.last_result && (out_data_o.face_index == '0) && (out_data_o.draw_blend == '0) && !out_data_o.is_quad)

  // The face that ends a frame closes the input until the results are out.
  `FDO_ASSERT_NEXT(a_last_stalls, clk_i, rst_ni, in_acc && in_data_i.last, in_stall_o)

  // While a frame is emitted no new face is taken.
  `FDO_ASSERT_SAME(a_emit_stalls, clk_i, rst_ni, out_valid_o && !out_data_o.last_result, in_stall_o)

  // The configuration port never holds off a write.
  `FDO_ASSERT_SAME(a_cfg_ready, clk_i, rst_ni, cfg_seen, cfg_ready_o)

endmodule

bind face_depth_order_engine fdo_checker u_fdo_checker (.*);
